// ===== sv/pse_pkg.sv =====
package pse_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    CMD_NUM  = 2'd0,
    CMD_OPER = 2'd1,
    CMD_END  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_FULL      = 3'd2,
    ST_LEFTOVER  = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [VALUE_W-1:0] operand_value;
    op_e                       op_code;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] result_value;
  } out_word_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_END_RD,
    S_EMIT
  } ctl_state_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL1,
    A_MUL2,
    A_MUL3,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_e;

endpackage

// ===== sv/pse_ram.sv =====
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pse_alu.sv =====
module pse_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pse_pkg::alu_req_t        req_i,
  input  logic [DATA_WIDTH-1:0]    a_i,
  input  logic [DATA_WIDTH-1:0]    b_i,
  output logic                     done_o,
  output logic [DATA_WIDTH-1:0]    result_o
);

  localparam int HALF_W = (DATA_WIDTH + 1) / 2;
  localparam int PROD_W = 2 * HALF_W;
  localparam int CNT_W  = $clog2(DATA_WIDTH);

  pse_pkg::alu_state_e state_q, state_d;

  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  neg_q, neg_d;

  logic [HALF_W-1:0]     m_x, m_y;
  logic [PROD_W-1:0]     prod;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH:0]   diff;

  // one shared half-width multiplier: low x low, high x low, low x high
  always_comb begin
    unique case (state_q)
      pse_pkg::A_MUL1: begin
        m_x = HALF_W'(a_q[DATA_WIDTH-1:HALF_W]);
        m_y = b_q[HALF_W-1:0];
      end
      pse_pkg::A_MUL2: begin
        m_x = a_q[HALF_W-1:0];
        m_y = HALF_W'(b_q[DATA_WIDTH-1:HALF_W]);
      end
      default: begin
        m_x = a_i[HALF_W-1:0];
        m_y = b_i[HALF_W-1:0];
      end
    endcase
    prod = PROD_W'(m_x) * PROD_W'(m_y);
  end

  // restoring divide step on magnitudes, quotient shifts into a_q
  always_comb begin
    rem_sh = {rem_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
    diff   = {1'b0, rem_sh} - {1'b0, b_q};
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_o  = 1'b0;
    unique case (state_q)
      pse_pkg::A_IDLE: begin
        if (req_i.start) begin
          a_d = a_i;
          b_d = b_i;
          case (req_i.op)
            pse_pkg::OP_ADD: begin
              acc_d   = a_i + b_i;
              state_d = pse_pkg::A_DONE;
            end
            pse_pkg::OP_SUB: begin
              acc_d   = a_i - b_i;
              state_d = pse_pkg::A_DONE;
            end
            pse_pkg::OP_MUL: begin
              prod_d  = prod;
              state_d = pse_pkg::A_MUL1;
            end
            default: begin
              neg_d   = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
              a_d     = a_i[DATA_WIDTH-1] ? -a_i : a_i;
              b_d     = b_i[DATA_WIDTH-1] ? -b_i : b_i;
              rem_d   = '0;
              cnt_d   = '0;
              state_d = pse_pkg::A_DIV;
            end
          endcase
        end
      end
      pse_pkg::A_MUL1: begin
        acc_d   = DATA_WIDTH'(prod_q);
        prod_d  = prod;
        state_d = pse_pkg::A_MUL2;
      end
      pse_pkg::A_MUL2: begin
        acc_d   = acc_q + (DATA_WIDTH'(prod_q) << HALF_W);
        prod_d  = prod;
        state_d = pse_pkg::A_MUL3;
      end
      pse_pkg::A_MUL3: begin
        acc_d   = acc_q + (DATA_WIDTH'(prod_q) << HALF_W);
        state_d = pse_pkg::A_DONE;
      end
      pse_pkg::A_DIV: begin
        a_d   = {a_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        rem_d = diff[DATA_WIDTH] ? rem_sh : diff[DATA_WIDTH-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
          state_d = pse_pkg::A_FIX;
        end
      end
      pse_pkg::A_FIX: begin
        acc_d   = neg_q ? -a_q : a_q;
        state_d = pse_pkg::A_DONE;
      end
      pse_pkg::A_DONE: begin
        done_o  = 1'b1;
        state_d = pse_pkg::A_IDLE;
      end
      default: begin
        state_d = pse_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  assign result_o = acc_q;

endmodule

// ===== sv/postfix_stack_evaluator.sv =====
// Postfix expression evaluator over a stream of classified tokens (number, operator, end).
// The stack lives in a single-read-port RAM with a registered read, one item is worked at a
// time: an operator reads its two operands in turn; multiply forms three half-width partial
// products through one multiplier and divide makes one quotient bit per cycle; an end token
// reads the result off the stack, and any result or error word waits while the output word
// is stalled.
// A result word waits in an output register while the next token is taken, unless that
// token also has a result to emit. After an error on a number or operator token the stack is
// dropped and tokens are skipped up to the next end token, which is consumed silently.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pse_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pse_pkg::out_word_t  out_word_o
);

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);

  pse_pkg::ctl_state_e state_q, state_d;

  logic [DEPTH_W-1:0]                 depth_q, depth_d;
  logic                               skip_q, skip_d;
  logic                               out_valid_q, out_valid_d;
  pse_pkg::out_word_t                 out_word_q, out_word_d;
  logic [DATA_WIDTH-1:0]              b_q, b_d;
  pse_pkg::op_e                       op_q, op_d;
  pse_pkg::status_e                   st_q, st_d;
  logic signed [pse_pkg::VALUE_W-1:0] res_q, res_d;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  pse_pkg::alu_req_t     alu_req;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;

  pse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pse_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (ram_rdata),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_comb begin
    state_d       = state_q;
    depth_d       = depth_q;
    skip_d        = skip_q;
    b_d           = b_q;
    op_d          = op_q;
    st_d          = st_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_word_d    = out_word_q;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(depth_q);
    ram_wdata     = DATA_WIDTH'(in_word_i.operand_value);
    ram_raddr     = ADDR_W'(depth_q - DEPTH_W'(1));
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    unique case (state_q)
      pse_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_word_i.cmd)
            pse_pkg::CMD_END: begin
              depth_d = '0;
              if (skip_q) begin
                skip_d = 1'b0;
              end else if (depth_q == '0) begin
                st_d    = pse_pkg::ST_UNDERFLOW;
                res_d   = '0;
                state_d = pse_pkg::S_EMIT;
              end else if (depth_q != DEPTH_W'(1)) begin
                st_d    = pse_pkg::ST_LEFTOVER;
                res_d   = '0;
                state_d = pse_pkg::S_EMIT;
              end else begin
                ram_raddr = '0;
                state_d   = pse_pkg::S_END_RD;
              end
            end
            pse_pkg::CMD_NUM: begin
              if (!skip_q) begin
                if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
                  depth_d = '0;
                  skip_d  = 1'b1;
                  st_d    = pse_pkg::ST_FULL;
                  res_d   = '0;
                  state_d = pse_pkg::S_EMIT;
                end else begin
                  ram_we  = 1'b1;
                  depth_d = depth_q + DEPTH_W'(1);
                end
              end
            end
            pse_pkg::CMD_OPER: begin
              if (!skip_q) begin
                if (depth_q < DEPTH_W'(2)) begin
                  depth_d = '0;
                  skip_d  = 1'b1;
                  st_d    = pse_pkg::ST_UNDERFLOW;
                  res_d   = '0;
                  state_d = pse_pkg::S_EMIT;
                end else begin
                  // top of stack is being read this cycle
                  op_d    = in_word_i.op_code;
                  state_d = pse_pkg::S_RD_B;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      pse_pkg::S_RD_B: begin
        b_d       = ram_rdata;
        ram_raddr = ADDR_W'(depth_q - DEPTH_W'(2));
        state_d   = pse_pkg::S_RD_A;
      end
      pse_pkg::S_RD_A: begin
        if (op_q == pse_pkg::OP_DIV && b_q == '0) begin
          depth_d = '0;
          skip_d  = 1'b1;
          st_d    = pse_pkg::ST_DIVZERO;
          res_d   = '0;
          state_d = pse_pkg::S_EMIT;
        end else begin
          alu_req.start = 1'b1;
          state_d       = pse_pkg::S_EXEC;
        end
      end
      pse_pkg::S_EXEC: begin
        ram_waddr = ADDR_W'(depth_q - DEPTH_W'(2));
        ram_wdata = alu_result;
        if (alu_done) begin
          ram_we  = 1'b1;
          depth_d = depth_q - DEPTH_W'(1);
          state_d = pse_pkg::S_IDLE;
        end
      end
      pse_pkg::S_END_RD: begin
        st_d    = pse_pkg::ST_OK;
        res_d   = pse_pkg::VALUE_W'($signed(ram_rdata));
        state_d = pse_pkg::S_EMIT;
      end
      pse_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = '{status: st_q, result_value: res_q};
          state_d     = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pse_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::S_IDLE;
      depth_q     <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q        <= b_d;
    op_q       <= op_d;
    st_q       <= st_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != pse_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_skip_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> depth_q == '0)
    else $error("stack not empty while skipping");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != pse_pkg::ST_OK |-> out_word_o.result_value == '0)
    else $error("error word carries a nonzero value");

  a_alu_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == pse_pkg::S_EXEC)
    else $error("arithmetic unit finished outside execute");

  a_push_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.cmd == pse_pkg::CMD_NUM && !skip_q &&
    depth_q != DEPTH_W'(STACK_DEPTH) |=> depth_q == $past(depth_q) + DEPTH_W'(1))
    else $error("push did not grow the stack");
`endif

endmodule

// ===== dv/pse_result_checker.sv =====
module pse_result_checker #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  pse_pkg::in_word_t   in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  pse_pkg::out_word_t  out_word_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [pse_pkg::VALUE_W-1:0] stack_mem [DEPTH];
  logic [CNT_W-1:0]            depth_cnt;
  bit                          skipping;
  pse_pkg::out_word_t          results_due [$];
  pse_pkg::out_word_t          want;
  pse_pkg::out_word_t          got;
  int                          fails = 0;

  // truncating signed divide; most negative over minus one wraps back to itself
  function automatic logic [pse_pkg::VALUE_W-1:0] quotient(
    logic [pse_pkg::VALUE_W-1:0] a,
    logic [pse_pkg::VALUE_W-1:0] b
  );
    logic [pse_pkg::VALUE_W-1:0] ma;
    logic [pse_pkg::VALUE_W-1:0] mb;
    logic [pse_pkg::VALUE_W-1:0] q;
    ma = a[pse_pkg::VALUE_W-1] ? -a : a;
    mb = b[pse_pkg::VALUE_W-1] ? -b : b;
    q  = ma / mb;
    return (a[pse_pkg::VALUE_W-1] ^ b[pse_pkg::VALUE_W-1]) ? -q : q;
  endfunction

  // applies one token to the stack, returns 1 when it produces a result word
  function automatic bit eval_token(input pse_pkg::in_word_t w, output pse_pkg::out_word_t r);
    logic [pse_pkg::VALUE_W-1:0] a;
    logic [pse_pkg::VALUE_W-1:0] b;
    logic [pse_pkg::VALUE_W-1:0] v;
    logic [CNT_W-1:0]            d;
    r.status       = pse_pkg::ST_OK;
    r.result_value = '0;
    case (w.cmd)
      pse_pkg::CMD_END: begin
        d         = depth_cnt;
        depth_cnt = '0;
        if (skipping) begin
          skipping = 1'b0;
          return 1'b0;
        end
        if (d == 0) r.status = pse_pkg::ST_UNDERFLOW;
        else if (d > 1) r.status = pse_pkg::ST_LEFTOVER;
        else r.result_value = stack_mem[0];
        return 1'b1;
      end
      pse_pkg::CMD_NUM: begin
        if (skipping) return 1'b0;
        if (depth_cnt >= DEPTH) begin
          depth_cnt = '0;
          skipping  = 1'b1;
          r.status  = pse_pkg::ST_FULL;
          return 1'b1;
        end
        stack_mem[depth_cnt] = w.operand_value;
        depth_cnt++;
        return 1'b0;
      end
      pse_pkg::CMD_OPER: begin
        if (skipping) return 1'b0;
        if (depth_cnt < 2) begin
          depth_cnt = '0;
          skipping  = 1'b1;
          r.status  = pse_pkg::ST_UNDERFLOW;
          return 1'b1;
        end
        b = stack_mem[depth_cnt-1];
        a = stack_mem[depth_cnt-2];
        case (w.op_code)
          pse_pkg::OP_ADD: v = a + b;
          pse_pkg::OP_SUB: v = a - b;
          pse_pkg::OP_MUL: v = a * b;
          default: begin
            if (b == 0) begin
              depth_cnt = '0;
              skipping  = 1'b1;
              r.status  = pse_pkg::ST_DIVZERO;
              return 1'b1;
            end
            v = quotient(a, b);
          end
        endcase
        depth_cnt--;
        stack_mem[depth_cnt-1] = v;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_cnt = '0;
      skipping  = 1'b0;
      results_due.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // result first: it belongs to a word taken on an earlier edge
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual status %0d value %0d",
                   $time, out_word_i.status, out_word_i.result_value);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (out_word_i.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_word_i.status);
            fails++;
          end
          if (out_word_i.result_value !== want.result_value) begin
            $display("%0t ns: result_value mismatch, expected %0d actual %0d",
                     $time, want.result_value, out_word_i.result_value);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (eval_token(in_word_i, got)) results_due.push_back(got);
      end
      pending_o    <= results_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== dv/tb_postfix_stack_evaluator.sv =====
module tb_postfix_stack_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int            DEPTH       = 64;
  localparam int            IDLE_LIMIT  = 4000;
  localparam int            PHASE_WORDS = 420;
  localparam pse_pkg::cmd_e CMD_UNUSED  = pse_pkg::cmd_e'(2'd3);

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  pse_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pse_pkg::out_word_t out_word;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int words_sent   = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  postfix_stack_evaluator #(
    .STACK_DEPTH(DEPTH),
    .DATA_WIDTH (pse_pkg::VALUE_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  pse_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // no word moving on either side for too long means the block is hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic pse_pkg::in_word_t token(pse_pkg::cmd_e c,
                                              logic [pse_pkg::VALUE_W-1:0] v,
                                              pse_pkg::op_e o);
    pse_pkg::in_word_t w;
    w.cmd           = c;
    w.operand_value = v;
    w.op_code       = o;
    return w;
  endfunction

  function automatic logic [pse_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hffff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      5, 6:    return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input pse_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_num(logic [pse_pkg::VALUE_W-1:0] v);
    send_word(token(pse_pkg::CMD_NUM, v, pse_pkg::op_e'($urandom_range(3))));
  endtask

  task automatic send_op(pse_pkg::op_e o);
    send_word(token(pse_pkg::CMD_OPER, $urandom, o));
  endtask

  task automatic send_end();
    send_word(token(pse_pkg::CMD_END, $urandom, pse_pkg::op_e'($urandom_range(3))));
  endtask

  // well-formed expression with random operands and operators
  task automatic send_expr(int operands);
    int left;
    int depth;
    left  = operands;
    depth = 0;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(1))) begin
        send_num(pick_value());
        left--;
        depth++;
      end else begin
        send_op(pse_pkg::op_e'($urandom_range(3)));
        depth--;
      end
    end
    send_end();
  endtask

  // random token kinds, the unused kind included, closed by an end word
  task automatic send_noise();
    repeat ($urandom_range(6, 1)) begin
      send_word(token(pse_pkg::cmd_e'($urandom_range(3)), pick_value(),
                      pse_pkg::op_e'($urandom_range(3))));
    end
    send_end();
  endtask

  // push a run of numbers; fold reduces them to one value without divides
  task automatic fill_stack(int pushes, bit fold);
    repeat (pushes) send_num(pick_value());
    if (fold) begin
      repeat (pushes - 1) send_op(pse_pkg::op_e'($urandom_range(2)));
    end
    send_end();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end on empty stack
    send_end();
    // add wraps
    send_num(32'h7fff_ffff);
    send_num(32'd1);
    send_op(pse_pkg::OP_ADD);
    send_end();
    // most negative over minus one
    send_num(32'h8000_0000);
    send_num(32'hffff_ffff);
    send_op(pse_pkg::OP_DIV);
    send_end();
    // divide by zero, then tokens skipped up to the end
    send_num(32'd7);
    send_num(32'd0);
    send_op(pse_pkg::OP_DIV);
    send_num(32'd5);
    send_op(pse_pkg::OP_SUB);
    send_end();
    // operator with too few values
    send_op(pse_pkg::OP_ADD);
    send_end();
    // values left over
    send_num(32'd3);
    send_num(32'd4);
    send_end();
    // negative quotient truncates toward zero, then multiply and subtract
    send_num(32'hffff_fff9);
    send_num(32'd2);
    send_op(pse_pkg::OP_DIV);
    send_num(32'h7fff_ffff);
    send_op(pse_pkg::OP_MUL);
    send_num(32'd5);
    send_op(pse_pkg::OP_SUB);
    send_end();
    // unused token kind is dropped
    send_word(token(CMD_UNUSED, 32'hffff_ffff, pse_pkg::OP_DIV));
    send_num(32'd9);
    send_end();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      target = words_sent + PHASE_WORDS;
      if (phase % 2 == 0) fill_stack(DEPTH + 1 + $urandom_range(2), 1'b0);
      else fill_stack(DEPTH, 1'b1);
      while (words_sent < target) begin
        r = $urandom_range(99);
        if (r < 5) drain();
        if (r < 82) begin
          if ($urandom_range(3) == 0) send_expr($urandom_range(12, 1));
          else send_expr($urandom_range(4, 1));
        end else begin
          send_noise();
        end
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== postfix_stack_evaluator.f =====
sv/pse_pkg.sv
sv/pse_ram.sv
sv/pse_alu.sv
sv/postfix_stack_evaluator.sv
dv/pse_result_checker.sv
dv/tb_postfix_stack_evaluator.sv
